// ===== rtl/core/crc8afc_pkg.sv =====
// ----------------------------------------------------------------------------
// crc8afc_pkg
// Types, constants and CRC helpers for the CRC-8 ASCII frame checker.
// ----------------------------------------------------------------------------
package crc8afc_pkg;

  localparam int unsigned LEN_W  = 9;
  localparam int unsigned IDX_W  = 2;

  localparam logic [7:0] CRC_POLY    = 8'hD5;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_LOW_A = 8'h61;
  localparam logic [3:0] DEC_DIGITS  = 4'd10;

  localparam logic [7:0]       ADDR_CHAR_RST = 8'd67;
  localparam logic [LEN_W-1:0] FRAME_LEN_RST = 9'd32;

  // configuration register indexes
  localparam logic [IDX_W-1:0] CFG_ADDR_FIRST  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_ADDR_SECOND = 2'd1;
  localparam logic [IDX_W-1:0] CFG_FRAME_LEN   = 2'd2;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_ADDR = 2'd1,
    ST_BAD_LEN  = 2'd2,
    ST_BAD_CRC  = 2'd3
  } status_t;

  // One byte of CRC-8, MSB first, no reflection.
  function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // Lowercase ASCII hex digit of a nibble.
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] d;
    if (nib < DEC_DIGITS) begin
      d = ASCII_ZERO + {4'b0, nib};
    end else begin
      d = ASCII_LOW_A + {4'b0, nib} - {4'b0, DEC_DIGITS};
    end
    return d;
  endfunction

endpackage

// ===== rtl/core/crc8_ascii_frame_checker_top.sv =====
// ----------------------------------------------------------------------------
// crc8_ascii_frame_checker_top
// Checks address, length and trailing hex CRC-8 of ASCII response frames,
// forwarding payload bytes as they arrive.
// ----------------------------------------------------------------------------
// An accepted input byte's result is registered and shown in the cycle
// after it is taken. Throughput: one byte per cycle unless the result
// stream stalls; the per-byte CRC fold (eight xor/shift steps) and the
// end-of-frame compare sit between frame state and result register.
// Reset: rst_n synchronous, active low; clears frame state, output valid and
// restores the configuration registers to their defaults.
module crc8_ascii_frame_checker_top
  import crc8afc_pkg::*;
#(
  parameter int unsigned MAX_FRAME     = 256,
  parameter int unsigned PAYLOAD_START = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  // configuration
  input  logic                cfg_we,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [LEN_W-1:0]    cfg_wdata,
  // input stream
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // [7:0] rx_byte
  input  logic                in_tlast,   // frame_end
  // result stream
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [31:0]         out_tdata,  // [7:0] payload_byte, [9:8] status,
                                          // [17:10] device_type,
                                          // [25:18] device_number, [31:26] zero
  output logic                out_tuser,  // payload_valid
  output logic                out_tlast   // frame_done
);

  localparam int unsigned CW   = $clog2(MAX_FRAME + 1);
  localparam int unsigned CMPW = (CW > 10) ? CW : 10;
  localparam logic [CW-1:0]   MAX_CNT = CW'(MAX_FRAME);
  localparam logic [CMPW-1:0] PAY_POS = CMPW'(PAYLOAD_START);

  // configuration
  logic [7:0]       addr_first_r;
  logic [7:0]       addr_second_r;
  logic [LEN_W-1:0] frame_len_r;

  // frame state
  logic [7:0]    crc_r,      crc_nxt;
  logic [CW-1:0] byte_cnt_r, byte_cnt_nxt;
  logic [7:0]    held0_r,    held0_nxt;
  logic [7:0]    held1_r,    held1_nxt;
  logic          addr_ok_r,  addr_ok_nxt;
  logic [7:0]    first_r,    first_nxt;
  logic [7:0]    second_r,   second_nxt;

  // result register
  logic          out_valid_r;
  logic          pay_valid_r, pay_valid_nxt;
  logic [7:0]    pay_byte_r,  pay_byte_nxt;
  logic          done_r,      done_nxt;
  status_t       status_r,    status_nxt;
  logic [7:0]    dev_type_r,  dev_type_nxt;
  logic [7:0]    dev_num_r,   dev_num_nxt;

  logic            in_acc;
  logic [CMPW-1:0] pos_x;
  logic [CMPW-1:0] flen_x;
  logic [CMPW-1:0] len_x;
  logic            in_payload;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    pos_x  = CMPW'(byte_cnt_r);
    flen_x = CMPW'(frame_len_r);

    first_nxt   = first_r;
    second_nxt  = second_r;
    addr_ok_nxt = addr_ok_r;
    if (byte_cnt_r == '0) begin
      first_nxt = in_tdata;
      if (in_tdata != addr_first_r) addr_ok_nxt = 1'b0;
    end else if (byte_cnt_r == CW'(1)) begin
      second_nxt = in_tdata;
      if (in_tdata != addr_second_r) addr_ok_nxt = 1'b0;
    end

    in_payload = (flen_x >= CMPW'(2)) && (pos_x >= PAY_POS) &&
                 (pos_x < flen_x - CMPW'(2));

    // two-byte delay line; bytes leaving it enter the CRC
    crc_nxt   = (byte_cnt_r >= CW'(2)) ? crc_fold(crc_r, held0_r) : crc_r;
    held0_nxt = held1_r;
    held1_nxt = in_tdata;

    byte_cnt_nxt = (byte_cnt_r < MAX_CNT) ? byte_cnt_r + CW'(1) : byte_cnt_r;
    len_x        = CMPW'(byte_cnt_nxt);

    pay_valid_nxt = in_payload;
    pay_byte_nxt  = in_payload ? in_tdata : 8'h00;
    done_nxt      = in_tlast;
    status_nxt    = ST_OK;
    dev_type_nxt  = 8'h00;
    dev_num_nxt   = 8'h00;

    if (in_tlast) begin
      if (len_x < CMPW'(2) || !addr_ok_nxt) begin
        status_nxt = ST_BAD_ADDR;
      end else if (len_x != flen_x) begin
        status_nxt = ST_BAD_LEN;
      end else if (held0_nxt != hex_digit(crc_nxt[7:4]) ||
                   held1_nxt != hex_digit(crc_nxt[3:0])) begin
        status_nxt = ST_BAD_CRC;
      end
      dev_type_nxt = first_nxt;
      dev_num_nxt  = second_nxt - ASCII_ZERO;
      // restart frame state for the next frame
      crc_nxt      = 8'h00;
      byte_cnt_nxt = '0;
      held0_nxt    = 8'h00;
      held1_nxt    = 8'h00;
      addr_ok_nxt  = 1'b1;
      first_nxt    = 8'h00;
      second_nxt   = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_first_r  <= ADDR_CHAR_RST;
      addr_second_r <= ADDR_CHAR_RST;
      frame_len_r   <= FRAME_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ADDR_FIRST:  addr_first_r  <= cfg_wdata[7:0];
        CFG_ADDR_SECOND: addr_second_r <= cfg_wdata[7:0];
        CFG_FRAME_LEN:   frame_len_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r      <= 8'h00;
      byte_cnt_r <= '0;
      held0_r    <= 8'h00;
      held1_r    <= 8'h00;
      addr_ok_r  <= 1'b1;
      first_r    <= 8'h00;
      second_r   <= 8'h00;
    end else if (in_acc) begin
      crc_r      <= crc_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      held0_r    <= held0_nxt;
      held1_r    <= held1_nxt;
      addr_ok_r  <= addr_ok_nxt;
      first_r    <= first_nxt;
      second_r   <= second_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pay_valid_r <= pay_valid_nxt;
      pay_byte_r  <= pay_byte_nxt;
      done_r      <= done_nxt;
      status_r    <= status_nxt;
      dev_type_r  <= dev_type_nxt;
      dev_num_r   <= dev_num_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = pay_valid_r;
  assign out_tlast  = done_r;
  assign out_tdata  = {6'b0, dev_num_r, dev_type_r, status_r, pay_byte_r};

`ifndef NO_ASSERTIONS
  // frame state is back to its idle values after a frame end
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |=> byte_cnt_r == '0 && addr_ok_r && crc_r == 8'h00)
    else $error("frame state not cleared after frame end");

  // byte count saturates
  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    byte_cnt_r <= MAX_CNT)
    else $error("byte count above maximum frame size");

  // frame report fields stay zero except on the frame's last byte
  a_report_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !done_r |-> status_r == ST_OK && dev_type_r == 8'h00 &&
                               dev_num_r == 8'h00)
    else $error("frame report outside frame end");

  // a held result blocks new input
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !in_tready)
    else $error("input taken while result is stalled");

  // a result is pending in the cycle after each accepted byte
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted byte produced no result");
`endif

endmodule

// ===== tb/crc8_ascii_frame_checker_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crc8_ascii_frame_checker_top_tb
// Self-checking bench: frames of bytes go into the checker and every result
// transaction is compared against a cycle-free model of the frame state
// (address, length, trailing hex CRC-8, payload window). Directed frames
// first, then mostly well-formed random frames under several register
// settings, with random stalls on both streams.
// ----------------------------------------------------------------------------
module crc8_ascii_frame_checker_top_tb;
  import crc8afc_pkg::*;

  localparam int FRAME_CAP   = 256;
  localparam int PAYLOAD_POS = 10;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic       pay_valid;
    logic [7:0] pay_byte;
    logic       done;
    status_t    status;
    logic [7:0] dev_type;
    logic [7:0] dev_num;
  } byte_result_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [LEN_W-1:0] cfg_wdata;
  logic             in_tvalid;
  logic             in_tready;
  logic [7:0]       in_tdata;
  logic             in_tlast;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [31:0]      out_tdata;
  logic             out_tuser;
  logic             out_tlast;

  // model copy of the registers and of the per-frame state
  logic [7:0]       cfg_addr_first;
  logic [7:0]       cfg_addr_second;
  logic [LEN_W-1:0] cfg_frame_len;
  logic [7:0]       frm_crc;
  logic [8:0]       frm_count;
  logic [7:0]       frm_hold [2];
  logic             frm_addr_ok;
  logic [7:0]       frm_first;
  logic [7:0]       frm_second;

  byte_result_t frame_results_due [$];
  logic [7:0]   frame_bytes [$];
  int           src_idle_pct;
  int           snk_idle_pct;
  int           bytes_sent;
  int           mismatch_count = 0;
  int           cycle_count = 0;

  crc8_ascii_frame_checker_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL crc8_ascii_frame_checker_top");
      $finish;
    end
  end

  function automatic logic [7:0] crc_step(logic [7:0] acc, logic [7:0] d);
    logic [7:0] r;
    r = acc ^ d;
    for (int i = 0; i < 8; i++) begin
      r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    return (n < 4'd10) ? (ASCII_ZERO + {4'b0, n}) : (ASCII_LOW_A + {4'b0, n} - 8'd10);
  endfunction

  function automatic void clear_frame_state();
    frm_crc     = '0;
    frm_count   = '0;
    frm_hold[0] = '0;
    frm_hold[1] = '0;
    frm_addr_ok = 1'b1;
    frm_first   = '0;
    frm_second  = '0;
  endfunction

  // Advances the frame state by one byte and returns the result it causes.
  function automatic byte_result_t frame_byte_result(logic [7:0] b, logic last);
    byte_result_t r;
    int           pos;
    int           len;
    r   = '0;
    pos = int'(frm_count);
    if (pos == 0) begin
      frm_first = b;
      if (b != cfg_addr_first) frm_addr_ok = 1'b0;
    end else if (pos == 1) begin
      frm_second = b;
      if (b != cfg_addr_second) frm_addr_ok = 1'b0;
    end
    if (cfg_frame_len >= 2 && pos >= PAYLOAD_POS && pos < int'(cfg_frame_len) - 2) begin
      r.pay_valid = 1'b1;
      r.pay_byte  = b;
    end
    // bytes leave the two-byte delay line into the CRC
    if (pos >= 2) frm_crc = crc_step(frm_crc, frm_hold[0]);
    frm_hold[0] = frm_hold[1];
    frm_hold[1] = b;
    if (frm_count < FRAME_CAP) frm_count++;
    if (last) begin
      len    = int'(frm_count);
      r.done = 1'b1;
      if (len < 2 || !frm_addr_ok) begin
        r.status = ST_BAD_ADDR;
      end else if (len != int'(cfg_frame_len)) begin
        r.status = ST_BAD_LEN;
      end else if (frm_hold[0] != hex_char(frm_crc[7:4]) ||
                   frm_hold[1] != hex_char(frm_crc[3:0])) begin
        r.status = ST_BAD_CRC;
      end else begin
        r.status = ST_OK;
      end
      r.dev_type = frm_first;
      r.dev_num  = frm_second - ASCII_ZERO;
      clear_frame_state();
    end
    return r;
  endfunction

  task automatic compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      mismatch_count++;
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
    end
  endtask

  // result side: random back-pressure and in-order compare
  always @(posedge clk) begin
    byte_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (frame_results_due.size() == 0) begin
        mismatch_count++;
        $error("unexpected result transaction 0x%0h", out_tdata);
      end else begin
        exp_r = frame_results_due.pop_front();
        compare_field("payload_valid", 32'(exp_r.pay_valid), 32'(out_tuser));
        compare_field("payload_byte", 32'(exp_r.pay_byte), 32'(out_tdata[7:0]));
        compare_field("frame_done", 32'(exp_r.done), 32'(out_tlast));
        compare_field("status", 32'(exp_r.status), 32'(out_tdata[9:8]));
        compare_field("device_type", 32'(exp_r.dev_type), 32'(out_tdata[17:10]));
        compare_field("device_number", 32'(exp_r.dev_num), 32'(out_tdata[25:18]));
        compare_field("tdata_pad", 32'd0, 32'(out_tdata[31:26]));
      end
    end
    out_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    frame_results_due.push_back(frame_byte_result(b, last));
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // random bytes; from four bytes on, address in front and hex CRC at the end
  task automatic build_frame(logic [7:0] a0, logic [7:0] a1, int len);
    logic [7:0] crc;
    frame_bytes = {};
    for (int i = 0; i < len; i++) frame_bytes.push_back(8'($urandom));
    if (len >= 4) begin
      frame_bytes[0] = a0;
      frame_bytes[1] = a1;
      crc = '0;
      for (int i = 0; i < len - 2; i++) crc = crc_step(crc, frame_bytes[i]);
      frame_bytes[len-2] = hex_char(crc[7:4]);
      frame_bytes[len-1] = hex_char(crc[3:0]);
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (frame_results_due.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_config(logic [7:0] a0, logic [7:0] a1, logic [LEN_W-1:0] len);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ADDR_FIRST;
    cfg_wdata <= {1'b0, a0};
    @(posedge clk);
    cfg_index <= CFG_ADDR_SECOND;
    cfg_wdata <= {1'b0, a1};
    @(posedge clk);
    cfg_index <= CFG_FRAME_LEN;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we          <= 1'b0;
    cfg_addr_first  = a0;
    cfg_addr_second = a1;
    cfg_frame_len   = len;
  endtask

  task automatic test_good_min_frame();
    write_config(ADDR_CHAR_RST, ADDR_CHAR_RST, 9'd4);
    build_frame(ADDR_CHAR_RST, ADDR_CHAR_RST, 4);
    send_frame();
  endtask

  // one byte only: fails on address, device number wraps below '0'
  task automatic test_short_frame();
    send_byte(ADDR_CHAR_RST, 1'b1);
  endtask

  task automatic test_bad_address();
    build_frame(ADDR_CHAR_RST, ADDR_CHAR_RST, 4);
    frame_bytes[1] ^= 8'h01;
    send_frame();
  endtask

  task automatic test_bad_length();
    build_frame(ADDR_CHAR_RST, ADDR_CHAR_RST, 5);
    send_frame();
  endtask

  task automatic test_bad_crc();
    build_frame(ADDR_CHAR_RST, ADDR_CHAR_RST, 4);
    frame_bytes[3] ^= 8'h20;
    send_frame();
  endtask

  task automatic test_byte_extremes();
    write_config(8'h00, 8'hFF, 9'd4);
    build_frame(8'h00, 8'hFF, 4);
    send_frame();
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // lengths below the usual range: CRC over nothing, then over one byte
  task automatic test_two_byte_length();
    logic [7:0] crc;
    write_config(ASCII_ZERO, ASCII_ZERO, 9'd2);
    send_byte(ASCII_ZERO, 1'b0);
    send_byte(ASCII_ZERO, 1'b1);
    crc = crc_step(8'h00, 8'hA5);
    write_config(8'hA5, hex_char(crc[7:4]), 9'd3);
    send_byte(8'hA5, 1'b0);
    send_byte(hex_char(crc[7:4]), 1'b0);
    send_byte(hex_char(crc[3:0]), 1'b1);
  endtask

  // mostly well-formed frames under the current registers, plus broken ones
  task automatic random_frames(int n_items);
    int start;
    int r;
    int len;
    start = bytes_sent;
    while (bytes_sent - start < n_items) begin
      r = $urandom_range(99);
      if (r < 62) begin
        build_frame(cfg_addr_first, cfg_addr_second, int'(cfg_frame_len));
      end else if (r < 72) begin
        build_frame(cfg_addr_first, cfg_addr_second, int'(cfg_frame_len));
        frame_bytes[$urandom_range(1)] ^= 8'($urandom_range(1, 255));
      end else if (r < 82) begin
        do len = $urandom_range(2, int'(cfg_frame_len) + 6); while (len == int'(cfg_frame_len));
        build_frame(cfg_addr_first, cfg_addr_second, len);
      end else if (r < 90) begin
        build_frame(cfg_addr_first, cfg_addr_second, int'(cfg_frame_len));
        frame_bytes[frame_bytes.size() - 1 - $urandom_range(1)] ^= 8'($urandom_range(1, 255));
      end else if (r < 95 && cfg_frame_len == 9'd256) begin
        // longer than the byte counter: count saturates, CRC keeps running
        build_frame(cfg_addr_first, cfg_addr_second, $urandom_range(257, 270));
      end else begin
        build_frame(8'h00, 8'h00, $urandom_range(1, 40));
        frame_bytes[0] = 8'($urandom);
      end
      send_frame();
    end
  endtask

  task automatic test_random_traffic();
    // reset values of the registers first
    random_frames(150);
    write_config(8'h00, 8'hFF, 9'd4);
    random_frames(100);
    write_config(8'($urandom), 8'($urandom), 9'($urandom_range(5, 40)));
    random_frames(120);
    src_idle_pct = 70;
    snk_idle_pct = 32;
    write_config(ADDR_CHAR_RST, ADDR_CHAR_RST, 9'd256);
    random_frames(300);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_config(8'($urandom), 8'($urandom), 9'($urandom_range(4, 64)));
    random_frames(150);
    write_config(ASCII_ZERO, ASCII_ZERO + 8'd9, 9'd16);
    random_frames(100);
  endtask

  // a default-length frame straight out of reset, before any register write
  task automatic test_random_traffic_defaults_guard();
    build_frame(ADDR_CHAR_RST, ADDR_CHAR_RST, int'(FRAME_LEN_RST));
    send_frame();
  endtask

  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_ADDR_FIRST;
    cfg_wdata      <= '0;
    in_tvalid      <= 1'b0;
    in_tdata       <= '0;
    in_tlast       <= 1'b0;
    src_idle_pct    = 32;
    snk_idle_pct    = 70;
    bytes_sent      = 0;
    cfg_addr_first  = ADDR_CHAR_RST;
    cfg_addr_second = ADDR_CHAR_RST;
    cfg_frame_len   = FRAME_LEN_RST;
    clear_frame_state();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_random_traffic_defaults_guard();
    test_good_min_frame();
    test_short_frame();
    test_bad_address();
    test_bad_length();
    test_bad_crc();
    test_byte_extremes();
    test_two_byte_length();
    write_config(ADDR_CHAR_RST, ADDR_CHAR_RST, FRAME_LEN_RST);
    test_random_traffic();

    settle();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS crc8_ascii_frame_checker_top");
    end else begin
      $display("FAIL crc8_ascii_frame_checker_top");
    end
    $finish;
  end

endmodule
